// File: hdl/xbm_hex_bitmap_decoder_macros.svh
// Assertion macros shared by the XBM decoder RTL.
`ifndef XBM_HEX_BITMAP_DECODER_MACROS_SVH
`define XBM_HEX_BITMAP_DECODER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define XBM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("xbm decoder: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define XBM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("xbm decoder: next-cycle check failed");

`endif

// File: hdl/xbm_pkg.sv
// Shared types, constants and helpers of the XBM hex bitmap decoder.
package xbm_pkg;

    localparam int DIM_W      = 15;
    localparam int COL_W      = 12;
    localparam int COUNT_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic [DIM_W-1:0] MAX_DIM = 15'd32767;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_X    = 8'h78;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIGIT = 2'd1,
        ST_EARLY_END = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_ZERO = 4'b0001,
        PH_X    = 4'b0010,
        PH_HIGH = 4'b0100,
        PH_LOW  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    // Pixel slice of one completed byte plus row/column bookkeeping.
    typedef struct packed {
        logic [7:0]         bits;
        logic [COUNT_W-1:0] count;
        logic               last_col;
        logic               done;
    } pix_info_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            h.value = c[3:0] + 4'd9;
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = {{(DIM_W-1){1'b0}}, 1'b1};
        end else if (v > MAX_DIM) begin
            r = MAX_DIM;
        end
        return r;
    endfunction

endpackage

// File: hdl/xbm_pixel_calc.sv
// Pixel slice, padding mask and end-of-row/end-of-image detection for one byte.
module xbm_pixel_calc (
    input  logic [xbm_pkg::DIM_W-1:0] image_width,
    input  logic [xbm_pkg::DIM_W-1:0] image_height,
    input  logic [xbm_pkg::COL_W-1:0] byte_column,
    input  logic [xbm_pkg::DIM_W-1:0] current_row,
    input  logic [7:0]                byte_value,
    output xbm_pkg::pix_info_t        info
);
    import xbm_pkg::*;

    logic [DIM_W-1:0]   width_eff;
    logic [DIM_W-1:0]   height_eff;
    logic [DIM_W:0]     width_plus;
    logic [COL_W:0]     row_bytes;
    logic [DIM_W-1:0]   first_pixel;
    logic [DIM_W-1:0]   remain;
    logic [COUNT_W-1:0] count;
    logic [8:0]         mask;

    always_comb begin
        width_eff   = clamp_dim(image_width);
        height_eff  = clamp_dim(image_height);
        width_plus  = {1'b0, width_eff} + 16'd7;
        row_bytes   = width_plus[DIM_W:3];
        first_pixel = {byte_column, 3'b000};
        remain      = (width_eff > first_pixel) ? (width_eff - first_pixel) : '0;
        count       = (remain > 15'd8) ? 4'd8 : remain[COUNT_W-1:0];
        mask        = (9'd1 << count) - 9'd1;

        info.bits     = byte_value & mask[7:0];
        info.count    = count;
        info.last_col = ({1'b0, byte_column} + 13'd1) >= row_bytes;
        info.done     = info.last_col && (({1'b0, current_row} + 16'd1) >= {1'b0, height_eff});
    end

endmodule

// File: hdl/xbm_hex_bitmap_decoder.sv
// Top level of the XBM hex bitmap decoder: text scan, byte assembly and result output.
//
//   channel  dir  handshake           payload
//   s_       in   s_tvalid/s_tready   tdata: text_char; tuser: end_of_text
//   m_       out  m_tvalid/m_tready   tdata: pixel bits/count/row/column; tlast; tuser: status
//   cfg_     in   cfg_wr_en           cfg_index, cfg_wr_data (write only)
//
// One character per cycle sustained while m_tready holds; an item passes through the
// character register and then the result register, which drives m_.
// The character register and the result register each hold one item; a stall
// on m_tready backs up through both before s_tready drops.
// aresetn is synchronous, active low; it clears scan state, sizes (to 1) and valids.
// After an error result or the final byte the block swallows all input until reset.
module xbm_hex_bitmap_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_wr_en,
    input  logic [xbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [xbm_pkg::DIM_W-1:0]          cfg_wr_data,
    // text input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] text_char
    input  logic                               s_tuser,   // [0] end_of_text
    // pixel results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] pixel_bits, [11:8] pixel_count, [26:12] row_index,
    // [38:27] column_byte, [39] zero fill
    output logic [xbm_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast,   // image_done
    output logic [xbm_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);
    import xbm_pkg::*;

    // configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       eot_reg;

    // scan state
    phase_t           phase_reg,   phase_next;
    logic [3:0]       nibble_reg,  nibble_next;
    logic [COL_W-1:0] column_reg,  column_next;
    logic [DIM_W-1:0] row_reg,     row_next;
    logic             stopped_reg, stopped_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_bits_reg,  out_bits_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic [DIM_W-1:0]   out_row_reg,   out_row_next;
    logic [COL_W-1:0]   out_col_reg,   out_col_next;
    logic               out_done_reg,  out_done_next;
    status_t            out_status_reg, out_status_next;

    logic      advance;
    logic      process;
    hex_t      digit;
    pix_info_t pix;

    // Result register can take a new item when empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign process  = in_valid_reg && advance && !stopped_reg;
    assign digit    = hex_decode(char_reg);

    xbm_pixel_calc u_pixel_calc (
        .image_width  (width_reg),
        .image_height (height_reg),
        .byte_column  (column_reg),
        .current_row  (row_reg),
        .byte_value   ({nibble_reg, digit.value}),
        .info         (pix)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 15'd1;
            height_reg <= 15'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data;
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    // Character register: load on every accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            char_reg <= s_tdata;
            eot_reg  <= s_tuser;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        nibble_next     = nibble_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        stopped_next    = stopped_reg;
        out_valid_next  = advance ? 1'b0 : out_valid_reg;
        out_bits_next   = out_bits_reg;
        out_count_next  = out_count_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_done_next   = out_done_reg;
        out_status_next = out_status_reg;

        if (process) begin
            // Error results carry the current position and no pixels.
            out_bits_next   = '0;
            out_count_next  = '0;
            out_row_next    = row_reg;
            out_col_next    = column_reg;
            out_done_next   = 1'b0;
            if (eot_reg) begin
                out_valid_next  = 1'b1;
                out_status_next = ST_EARLY_END;
                stopped_next    = 1'b1;
            end else begin
                case (phase_reg)
                    PH_ZERO: begin
                        if (char_reg == CHAR_ZERO) begin
                            phase_next = PH_X;
                        end
                    end
                    PH_X: begin
                        // a repeated '0' keeps waiting for the 'x'
                        if (char_reg == CHAR_X) begin
                            phase_next = PH_HIGH;
                        end else if (char_reg != CHAR_ZERO) begin
                            phase_next = PH_ZERO;
                        end
                    end
                    PH_HIGH: begin
                        if (!digit.ok) begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_BAD_DIGIT;
                            stopped_next    = 1'b1;
                        end else begin
                            nibble_next = digit.value;
                            phase_next  = PH_LOW;
                        end
                    end
                    PH_LOW: begin
                        out_valid_next = 1'b1;
                        if (!digit.ok) begin
                            out_status_next = ST_BAD_DIGIT;
                            stopped_next    = 1'b1;
                        end else begin
                            phase_next      = PH_ZERO;
                            out_bits_next   = pix.bits;
                            out_count_next  = pix.count;
                            out_done_next   = pix.done;
                            out_status_next = ST_OK;
                            // advance column, wrap to next row, or stop at image end
                            if (pix.done) begin
                                stopped_next = 1'b1;
                            end else if (pix.last_col) begin
                                column_next = '0;
                                row_next    = row_reg + 15'd1;
                            end else begin
                                column_next = column_reg + 12'd1;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_ZERO;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_ZERO;
            nibble_reg    <= '0;
            column_reg    <= '0;
            row_reg       <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            nibble_reg    <= nibble_next;
            column_reg    <= column_next;
            row_reg       <= row_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
        out_bits_reg   <= out_bits_next;
        out_count_reg  <= out_count_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_done_reg   <= out_done_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_col_reg, out_row_reg, out_count_reg, out_bits_reg};
    assign m_tlast  = out_done_reg;
    assign m_tuser  = out_status_reg;

    `include "xbm_hex_bitmap_decoder_macros.svh"

    // error results carry no pixels and never flag image end
    `XBM_ASSERT_IMP(a_err_empty, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), (m_tdata[11:8] == 4'd0) && !m_tlast)
    // an error or final byte on the output means the scanner has stopped
    `XBM_ASSERT_IMP(a_stop_set, aclk, aresetn, m_tvalid && (m_tlast || (m_tuser != ST_OK)), stopped_reg)
    // once stopped and drained, no further result appears
    `XBM_ASSERT_NXT(a_stop_quiet, aclk, aresetn, stopped_reg && (!m_tvalid || m_tready), !m_tvalid)
    // pixel count never exceeds one byte
    `XBM_ASSERT_IMP(a_count_range, aclk, aresetn, m_tvalid, m_tdata[11:8] <= 4'd8)

endmodule
